FILE: rtl/dxt1p_pkg.sv
package dxt1p_pkg;

  localparam int unsigned NumPix  = 16;
  localparam int unsigned SumW    = 22;
  localparam int unsigned DistW   = 18;
  localparam logic [23:0] BestInit = 24'hffffff;

  // data handed from cell to cell along the chain
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [3:0][23:0] cand;
    logic [SumW-1:0]  sum;
    logic [31:0]      idx;
  } link_t;

  // floor(x/3) for x up to 765, by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    begin
      p = 21'(x) * 21'd683;
      div3 = p[18:11];
    end
  endfunction

  // floor(x/255) for x below 65535
  function automatic logic [15:0] div255(input logic [15:0] x);
    logic [16:0] s;
    begin
      s = 17'(x) + 17'd1 + 17'(x[15:8]);
      div255 = 16'(s[16:8]);
    end
  endfunction

  // squared distance between two packed pixels
  function automatic logic [DistW-1:0] dist_sq(input logic [23:0] p, input logic [23:0] q);
    logic [7:0]       d;
    logic [DistW-1:0] s;
    begin
      s = '0;
      for (int c = 0; c < 3; c++) begin
        d = (p[8*c +: 8] > q[8*c +: 8]) ? p[8*c +: 8] - q[8*c +: 8]
                                        : q[8*c +: 8] - p[8*c +: 8];
        s = s + DistW'(16'(d) * 16'(d));
      end
      dist_sq = s;
    end
  endfunction

  // 565 quantisation, channel 0 in the low bits
  function automatic logic [15:0] to565(input logic [23:0] v);
    logic [15:0] r, g, b;
    begin
      r = div255(16'(v[7:0]) * 16'd31);
      g = div255(16'(v[15:8]) * 16'd63);
      b = div255(16'(v[23:16]) * 16'd31);
      to565 = {b[4:0], g[5:0], r[4:0]};
    end
  endfunction

endpackage

FILE: rtl/dxt1p_pair_gen.sv
module dxt1p_pair_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [3:0]          wr_addr_i,
  input  logic [23:0]         wr_data_i,
  input  logic                start_i,
  output dxt1p_pkg::link_t    link_o
);

  logic [23:0] mem [16];
  logic        run_q, run_d;
  logic [3:0]  i_q, i_d, j_q, j_d;
  logic        v1_q, l1_q;
  logic [23:0] a_q, b_q;
  dxt1p_pkg::link_t link_q, link_d;
  logic        last_pair;

  assign last_pair = (i_q == 4'd14);

  // pixel memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    a_q <= mem[i_q];
    b_q <= mem[j_q];
  end

  // pair counter, i below j
  always_comb begin
    run_d = run_q;
    i_d   = i_q;
    j_d   = j_q;
    if (start_i) begin
      run_d = 1'b1;
      i_d   = 4'd0;
      j_d   = 4'd1;
    end else if (run_q) begin
      if (last_pair) begin
        run_d = 1'b0;
      end else if (j_q == 4'd15) begin
        i_d = i_q + 4'd1;
        j_d = i_q + 4'd2;
      end else begin
        j_d = j_q + 4'd1;
      end
    end
  end

  // candidate colours
  always_comb begin
    link_d      = '0;
    link_d.vld  = v1_q;
    link_d.last = l1_q;
    link_d.cand[0] = a_q;
    link_d.cand[1] = b_q;
    for (int c = 0; c < 3; c++) begin
      link_d.cand[2][8*c +: 8] = dxt1p_pkg::div3({1'b0, a_q[8*c +: 8], 1'b0}
                                                 + 10'(b_q[8*c +: 8]));
      link_d.cand[3][8*c +: 8] = dxt1p_pkg::div3(10'(a_q[8*c +: 8])
                                                 + {1'b0, b_q[8*c +: 8], 1'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      link_q <= '0;
    end else begin
      run_q  <= run_d;
      i_q    <= i_d;
      j_q    <= j_d;
      v1_q   <= run_q;
      l1_q   <= run_q & last_pair;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

FILE: rtl/dxt1p_cell.sv
module dxt1p_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [23:0]       pix_i,
  output logic [23:0]       pix_o,
  input  dxt1p_pkg::link_t  link_i,
  output dxt1p_pkg::link_t  link_o
);

  logic [23:0] pix_q;
  logic [dxt1p_pkg::DistW-1:0] d [4];
  logic [dxt1p_pkg::DistW-1:0] m;
  logic [1:0]  sel;
  dxt1p_pkg::link_t link_q, link_d;

  // pixel shifts along the chain while a tile loads
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_q <= pix_i;
    end
  end
  assign pix_o = pix_q;

  // nearest candidate, earlier wins a tie
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      d[n] = dxt1p_pkg::dist_sq(pix_q, link_i.cand[n]);
    end
    m   = d[0];
    sel = 2'd0;
    for (int n = 1; n < 4; n++) begin
      if (d[n] < m) begin
        m   = d[n];
        sel = 2'(n);
      end
    end
    link_d     = link_i;
    link_d.sum = link_i.sum + dxt1p_pkg::SumW'(m);
    link_d.idx = {sel, link_i.idx[31:2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

FILE: rtl/dxt1_block_encoder_pair_search.sv
// DXT1 colour-block encoder with an exhaustive endpoint-pair search.
// Input channel (in_valid_i/in_ready_o): one pixel per item, 16 items per
// 4x4 tile in line order. Output channel (out_valid_o/out_ready_i): one
// encoded block per tile, endpoints and a 32-bit index word.
// Pixels 1..15 of a tile are taken one per cycle. The 16th starts the search:
// the 120 endpoint pairs are issued one per cycle into a chain of 16 cells,
// each cell holding one pixel and adding its nearest error to the running
// sum as the pair passes. The block then takes no pixel until the search
// ends; the block is valid once the last pair has been issued and has passed
// the pair read, the candidate register, the 16 cells, the best-pair
// selection and the output packing register.
// A finished block waits in the output register; while it waits the next
// tile's first 15 pixels are still taken, the 16th only once it has gone.
// cfg_we_i writes bottom_up (reversed line order of the index bytes).
// Reset clears the pixel count, the search and the output; stored pixel
// values are not cleared.
module dxt1_block_encoder_pair_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  chan_low_i,
  input  logic [7:0]  chan_mid_i,
  input  logic [7:0]  chan_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] endpoint_first_o,
  output logic [15:0] endpoint_second_o,
  output logic [31:0] index_word_o
);

  logic        bottom_up_q;
  logic [3:0]  count_q;
  logic        busy_q, fin_q, out_valid_q;
  logic        in_acc, start;
  logic [23:0] pix_in;
  logic [23:0] best_q;
  logic [23:0] ba_q, bb_q;
  logic [31:0] bidx_q;
  logic [15:0] e0_q, e1_q;
  logic [31:0] word_q;
  logic [15:0] e0, e1, q0, q1;
  logic [31:0] fidx, word;

  logic [23:0]      pix   [17];
  dxt1p_pkg::link_t link  [17];

  assign in_ready_o = !busy_q && !((count_q == 4'd15) && out_valid_q);
  assign in_acc     = in_valid_i && in_ready_o;
  assign start      = in_acc && (count_q == 4'd15);
  assign pix_in     = {chan_high_i, chan_mid_i, chan_low_i};
  assign pix[16]    = pix_in;

  // pair issue and candidates
  dxt1p_pair_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (count_q),
    .wr_data_i (pix_in),
    .start_i   (start),
    .link_o    (link[0])
  );

  // chain of cells, cell k holds pixel k once the tile is in
  for (genvar k = 0; k < 16; k++) begin : g_cell
    dxt1p_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .load_i (in_acc),
      .pix_i  (pix[k+1]),
      .pix_o  (pix[k]),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  // ordering, tie fix-up and packing
  always_comb begin
    q0   = dxt1p_pkg::to565(ba_q);
    q1   = dxt1p_pkg::to565(bb_q);
    e0   = q0;
    e1   = q1;
    fidx = bidx_q;
    if (q0 < q1) begin
      e0   = q1;
      e1   = q0;
      fidx = bidx_q ^ 32'h5555_5555;
    end else if (q0 == q1) begin
      if (q1[4:0] != 5'd0) begin
        e1 = q1 - 16'd1;
      end else begin
        e0 = q0 + 16'd1;
      end
    end
    for (int r = 0; r < 4; r++) begin
      if (bottom_up_q) begin
        word[8*(3-r) +: 8] = fidx[8*r +: 8];
      end else begin
        word[8*r +: 8] = fidx[8*r +: 8];
      end
    end
  end

  // best pair tracking and output register
  always_ff @(posedge clk_i) begin
    if (start) begin
      best_q <= dxt1p_pkg::BestInit;
    end else if (link[16].vld && (24'(link[16].sum) < best_q)) begin
      best_q <= 24'(link[16].sum);
      ba_q   <= link[16].cand[0];
      bb_q   <= link[16].cand[1];
      bidx_q <= link[16].idx;
    end
    if (fin_q) begin
      e0_q   <= e0;
      e1_q   <= e1;
      word_q <= word;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_up_q <= 1'b0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bottom_up_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        count_q <= count_q + 4'd1;
      end
      if (start) begin
        busy_q <= 1'b1;
      end else if (fin_q) begin
        busy_q <= 1'b0;
      end
      fin_q <= link[16].vld && link[16].last;
      if (fin_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign endpoint_first_o  = e0_q;
  assign endpoint_second_o = e1_q;
  assign index_word_o      = word_q;

  // checks
  a_busy_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("pixel taken during search");
  a_fin_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !out_valid_q) else $error("result overwritten");
  a_start_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> (count_q == 4'd0)) else $error("search started mid tile");
  a_chain_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[16].vld |-> busy_q) else $error("pair outside a search");

endmodule
